// File: rtl/core/clock_frame_replacement_defines.svh
// Assertion macros for the clock frame replacement block.
`ifndef CLOCK_FRAME_REPLACEMENT_DEFINES_SVH
`define CLOCK_FRAME_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define CFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfr assertion failed");

// Next-cycle implication.
`define CFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfr assertion failed");

`else

`define CFR_ASSERT_IMP(lbl, ante, cons)
`define CFR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/cfr_pkg.sv
// Types and constants shared by the clock frame replacement block.
package cfr_pkg;

  localparam int REQ_W   = 3;
  localparam int FRAME_W = 6;
  localparam int OWNER_W = 8;
  localparam int PAGE_W  = 20;
  localparam int SCAN_W  = 13;

  localparam logic [SCAN_W-1:0] SCAN_LIMIT_RESET = 13'd1024;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NO_VICTIM = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSTALL       = 3'd0,
    REQ_ACCESSED      = 3'd1,
    REQ_PIN           = 3'd2,
    REQ_UNPIN         = 3'd3,
    REQ_RELEASE       = 3'd4,
    REQ_RELEASE_OWNER = 3'd5,
    REQ_EVICT         = 3'd6
  } req_type_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_FINISH
  } state_t;

  // One frame slot as held in the slot RAM
  typedef struct packed {
    logic               valid;
    logic               pinned;
    logic               accessed;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
  } slot_t;

  // Verdict of the slot evaluation unit on one visited slot
  typedef struct packed {
    logic  wr_en;
    slot_t wr_word;
    logic  freed;
    logic  victim;
  } slot_eval_t;

endpackage

// File: rtl/core/cfr_if.sv
// Handshake interfaces: request, result and configuration channels.
interface cfr_req_if import cfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [FRAME_W-1:0] frame_index;
  logic [OWNER_W-1:0] owner_id;
  logic [PAGE_W-1:0]  page_number;

  modport source (output valid, req_type, frame_index, owner_id, page_number,
                  input ready);
  modport sink   (input valid, req_type, frame_index, owner_id, page_number,
                  output ready);
endinterface

interface cfr_rsp_if import cfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [FRAME_W-1:0] victim_index;
  logic [PAGE_W-1:0]  victim_page;
  logic [OWNER_W-1:0] victim_owner;

  modport source (output valid, status, victim_index, victim_page, victim_owner,
                  input ready);
  modport sink   (input valid, status, victim_index, victim_page, victim_owner,
                  output ready);
endinterface

interface cfr_cfg_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SCAN_W-1:0] scan_limit;

  modport source (output valid, scan_limit, input ready);
  modport sink   (input valid, scan_limit, output ready);
endinterface

// File: rtl/core/cfr_slot_ram.sv
// Frame slot RAM: one write port, one read port with registered data.
module cfr_slot_ram import cfr_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_t         wdata,
  input  logic [AW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cfr_slot_eval.sv
// Slot evaluation unit: decides the update of one visited slot for a request.
module cfr_slot_eval import cfr_pkg::*; (
  input  req_type_t          op,
  input  slot_t              rd,
  input  logic [OWNER_W-1:0] owner,
  output slot_eval_t         res
);

  slot_t freed_word;

  // Freed slot keeps its owner and page, flags drop
  always_comb begin
    freed_word          = rd;
    freed_word.valid    = 1'b0;
    freed_word.pinned   = 1'b0;
    freed_word.accessed = 1'b0;
  end

  always_comb begin
    res         = '0;
    res.wr_word = rd;
    unique case (op)
      REQ_ACCESSED: begin
        res.wr_en            = rd.valid;
        res.wr_word.accessed = 1'b1;
      end
      REQ_PIN: begin
        res.wr_en          = rd.valid;
        res.wr_word.pinned = 1'b1;
      end
      REQ_UNPIN: begin
        res.wr_en          = rd.valid;
        res.wr_word.pinned = 1'b0;
      end
      REQ_RELEASE: begin
        res.wr_en   = rd.valid;
        res.wr_word = freed_word;
        res.freed   = rd.valid;
      end
      REQ_RELEASE_OWNER: begin
        res.wr_en   = rd.valid && (rd.owner == owner);
        res.wr_word = freed_word;
        res.freed   = rd.valid && (rd.owner == owner);
      end
      REQ_EVICT: begin
        // Second chance: a recently used slot loses its accessed bit
        res.wr_en = rd.valid && !rd.pinned;
        if (!rd.accessed) begin
          res.wr_word = freed_word;
          res.freed   = rd.valid && !rd.pinned;
          res.victim  = rd.valid && !rd.pinned;
        end else begin
          res.wr_word.accessed = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/clock_frame_replacement.sv
// Install and unused codes visit no slot; accessed/pin/unpin/release visit the slot if in range;
// release owner visits every slot; evict stops at a victim or scan_limit, none if it is 0.
// One slot is visited per cycle; a new item is taken only once the last result is loaded.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) starts a clearing pass over every slot of the
// slot RAM; no item is accepted until it ends. Configuration writes are taken at any time.
`include "clock_frame_replacement_defines.svh"

module clock_frame_replacement import cfr_pkg::*; #(
  parameter int NUM_FRAMES = 64
) (
  input  logic    clk,
  input  logic    rst,
  cfr_req_if.sink   req,
  cfr_rsp_if.source rsp,
  cfr_cfg_if.sink   cfg
);

  localparam int AW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CMP_W = (AW + 1 > FRAME_W) ? AW + 1 : FRAME_W;
  localparam logic [AW-1:0] LAST = AW'(NUM_FRAMES - 1);

  state_t             state, state_next;
  logic [AW-1:0]      hand;
  logic [AW-1:0]      scan_pos;
  logic [SCAN_W-1:0]  remain;
  logic [SCAN_W-1:0]  scan_limit;
  req_type_t          op;
  logic [OWNER_W-1:0] owner_q;

  logic               res_status;
  logic [FRAME_W-1:0] res_index;
  logic [PAGE_W-1:0]  res_page;
  logic [OWNER_W-1:0] res_owner;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  slot_t              mem_wdata;
  logic [AW-1:0]      mem_raddr;
  slot_t              mem_rdata;
  slot_eval_t         eval;

  logic               accept;
  req_type_t          req_op;
  logic               idx_ok;
  logic [AW-1:0]      req_addr;
  logic               scan_end;
  logic               evict_last;
  logic               out_load;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    next_slot = (s == LAST) ? '0 : s + 1'b1;
  endfunction

  assign req.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = req.valid && req.ready;
  assign req_op     = req_type_t'(req.req_type);
  assign idx_ok     = CMP_W'(req.frame_index) < CMP_W'(NUM_FRAMES);
  assign req_addr   = AW'(req.frame_index);
  assign scan_end   = (scan_pos == LAST);
  assign evict_last = (remain == SCAN_W'(1));
  assign out_load   = (state == ST_FINISH) && (!rsp.valid || rsp.ready);

  cfr_slot_ram #(
    .DEPTH (NUM_FRAMES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cfr_slot_eval u_eval (
    .op    (op),
    .rd    (mem_rdata),
    .owner (owner_q),
    .res   (eval)
  );

  // Scan limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= SCAN_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      scan_limit <= cfg.scan_limit;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (scan_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_op)
            REQ_ACCESSED, REQ_PIN, REQ_UNPIN, REQ_RELEASE:
              state_next = idx_ok ? ST_VISIT : ST_FINISH;
            REQ_RELEASE_OWNER: state_next = ST_VISIT;
            REQ_EVICT:
              state_next = (scan_limit != '0) ? ST_VISIT : ST_FINISH;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_VISIT: begin
        unique case (op)
          REQ_RELEASE_OWNER: state_next = scan_end ? ST_FINISH : ST_VISIT;
          REQ_EVICT:
            state_next = (eval.victim || evict_last) ? ST_FINISH : ST_VISIT;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_pos;
    mem_wdata = eval.wr_word;
    mem_raddr = next_slot(scan_pos);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we    = accept && (req_op == REQ_INSTALL) && idx_ok;
        mem_waddr = req_addr;
        mem_wdata = '{valid: 1'b1, pinned: 1'b0, accessed: 1'b0,
                      owner: req.owner_id, page: req.page_number};
        if (req_op == REQ_EVICT) begin
          mem_raddr = hand;
        end else if (req_op == REQ_RELEASE_OWNER) begin
          mem_raddr = '0;
        end else begin
          mem_raddr = req_addr;
        end
      end
      ST_VISIT: begin
        mem_we = eval.wr_en;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clock hand and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      hand     <= '0;
      scan_pos <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: scan_pos <= next_slot(scan_pos);
        ST_IDLE: begin
          if (accept) begin
            if (req_op == REQ_EVICT) begin
              scan_pos <= hand;
            end else if (req_op == REQ_RELEASE_OWNER) begin
              scan_pos <= '0;
            end else begin
              scan_pos <= req_addr;
            end
          end
        end
        ST_VISIT: begin
          scan_pos <= next_slot(scan_pos);
          // Eviction walks the hand; freeing the slot under it moves it on
          if (op == REQ_EVICT) begin
            hand <= next_slot(hand);
          end else if (eval.freed && (hand == scan_pos)) begin
            hand <= next_slot(hand);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request fields and result held during the walk
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      op         <= req_op;
      owner_q    <= req.owner_id;
      remain     <= scan_limit;
      res_status <= (req_op == REQ_EVICT && scan_limit == '0) ? STATUS_NO_VICTIM
                                                              : STATUS_OK;
      res_index  <= '0;
      res_page   <= '0;
      res_owner  <= '0;
    end else if (state == ST_VISIT) begin
      remain <= remain - 1'b1;
      if (eval.victim) begin
        res_index <= FRAME_W'(scan_pos);
        res_page  <= mem_rdata.page;
        res_owner <= mem_rdata.owner;
      end else if (op == REQ_EVICT && evict_last) begin
        res_status <= STATUS_NO_VICTIM;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status       <= res_status;
      rsp.victim_index <= res_index;
      rsp.victim_page  <= res_page;
      rsp.victim_owner <= res_owner;
    end
  end

  `CFR_ASSERT_IMP(a_hand_in_range, 1'b1, hand <= LAST)
  `CFR_ASSERT_IMP(a_evict_budget, state == ST_VISIT && op == REQ_EVICT, remain != '0)
  `CFR_ASSERT_NXT(a_result_loaded, out_load, rsp.valid)
  `CFR_ASSERT_IMP(a_idle_write_install, state == ST_IDLE && mem_we, accept && req_op == REQ_INSTALL)

endmodule
